>>> hdl/cochlear_filterbank_front_end_assert.svh
// Assertion macros shared by the checker of the cochlear filterbank front end.
// Uses clk and arst_n of the scope where a macro is expanded.
`ifndef COCHLEAR_FILTERBANK_FRONT_END_ASSERT_SVH
`define COCHLEAR_FILTERBANK_FRONT_END_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CFBFE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfbfe check failed");

// consequent must hold in the cycle after the antecedent
`define CFBFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfbfe check failed");

`endif

>>> hdl/cfbfe_pkg.sv
// Package of the cochlear filterbank front end: sizes, constants, word types, states.
// No dependencies.
package cfbfe_pkg;

	localparam int CHANNELS     = 32;
	localparam int FILTER_ORDER = 7;
	localparam int COEF_SLOTS   = 15;
	localparam int A_SLOT0      = 8;   // a1 sits in slot 8

	localparam int CH_W       = $clog2(CHANNELS);
	localparam int K_W        = $clog2(FILTER_ORDER + 1);
	localparam int COEF_DEPTH = CHANNELS * COEF_SLOTS;
	localparam int COEF_AW    = $clog2(COEF_DEPTH);
	localparam int DLY_DEPTH  = CHANNELS * FILTER_ORDER;
	localparam int DLY_AW     = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
	localparam int DLY_W      = 40;
	localparam int LEVEL_W    = 23;
	localparam int SIG_W      = 16;
	localparam int QUO_W      = 15;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int STEP_W     = 4;

	// reciprocals for exact floor division of values below 2^28, shift 30
	localparam logic [27:0] RECIP5 = 28'd214748365;
	localparam logic [28:0] RECIP3 = 29'd357913942;
	// 0.9845 in Q.24
	localparam logic [23:0] LEAK   = 24'd16517169;
	localparam logic [31:0] ONE31  = 32'h8000_0000;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_LOAD   = 1'b1
	} op_t;

	typedef struct packed {
		logic               op;
		logic signed [15:0] sample;
		logic [5:0]         coef_channel;
		logic [3:0]         coef_slot;
		logic signed [31:0] coef_value;
	} item_t;

	typedef struct packed {
		logic [5:0]         channel;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B0_RD,
		ST_B0_MUL,
		ST_Y,
		ST_TAP_RD,
		ST_TAP_BMUL,
		ST_TAP_AMUL,
		ST_TAP_WR,
		ST_SIG_MUL,
		ST_SIG_UPD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_INT_MUL,
		ST_INT_UPD,
		ST_EMIT
	} state_t;

endpackage

>>> hdl/cfbfe_mul.sv
// Shared signed multiplier with a registered product.
// Depends on cfbfe_pkg.
module cfbfe_mul import cfbfe_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod_q
);

	// product is registered and ready in the cycle after the operands
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

>>> hdl/cfbfe_div.sv
// Restoring divider for the sigmoid: q = (2^16 h + 2^31 + h) / (2^32 + 2h).
// One quotient bit per cycle. Depends on cfbfe_pkg.
module cfbfe_div import cfbfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      h,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	localparam int NUM_W = 48;
	localparam int DEN_W = 34;
	localparam int REM_W = DEN_W + 1;
	localparam int CNT_W = $clog2(QUO_W + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] den;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] low_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W-1:0] trial;
	logic             ge;

	// operands; the quotient is below 2^15 so the top bits start as remainder
	assign num   = {h, 16'b0} + NUM_W'(ONE31) + NUM_W'(h);
	assign den   = {2'b01, 32'b0} + DEN_W'({h, 1'b0});
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num[NUM_W-1:QUO_W]);
			low_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> hdl/cfbfe_core.sv
// Sequencer, coefficient/delay/integrator storage and datapath of the filterbank.
// Depends on cfbfe_pkg, cfbfe_mul, cfbfe_div.
module cfbfe_core import cfbfe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    take,
	input  item_t   item_in,
	input  logic    res_ready,
	output logic    busy,
	output logic    res_push,
	output result_t res_word
);

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
	localparam logic [K_W-1:0]  LAST_K  = K_W'(FILTER_ORDER - 1);

	// sigmoid micro steps
	localparam logic [STEP_W-1:0] STEP_DIV5 = 4'd0;
	localparam logic [STEP_W-1:0] STEP_Q4   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_W3   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_DIV3 = 4'd3;
	localparam logic [STEP_W-1:0] STEP_Q2   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_Q1   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_END  = 4'd13;

	localparam logic signed [PROD_W-1:0] HALF15 = 66'sd16384;
	localparam logic signed [PROD_W-1:0] HALF24 = 66'sd8388608;
	localparam logic signed [40:0] Y_MAX = 41'sd2147483647;
	localparam logic signed [40:0] Y_MIN = -41'sd2147483648;
	localparam logic signed [41:0] D_MAX = 42'sd549755813887;
	localparam logic signed [41:0] D_MIN = -42'sd549755813888;

	state_t state_q, state_d;

	logic signed [15:0]      x_q;
	logic [CH_W-1:0]         c_q;
	logic [K_W-1:0]          k_q;
	logic signed [DLY_W-1:0] d_q;
	logic signed [31:0]      y_q;
	logic signed [41:0]      acc_q;
	logic [27:0]             r_q;
	logic                    yneg_q;
	logic [31:0]             h_q;
	logic [STEP_W-1:0]       step_q;
	logic [SIG_W-1:0]        sig_prev_q;
	logic [SIG_W-1:0]        rect_q;
	logic [CH_W-1:0]         emit_q;
	result_t                 res_q;

	// storage
	logic [31:0]             coef_mem [COEF_DEPTH];
	logic signed [31:0]      coef_rd_q;
	logic [DLY_W-1:0]        dly_mem [DLY_DEPTH];
	logic [DLY_DEPTH-1:0]    dly_vld_q;
	logic [DLY_W-1:0]        dly_rd_q;
	logic                    dly_rd_vld_q;
	logic [LEVEL_W-1:0]      integ_q [CHANNELS];

	logic [COEF_AW-1:0]      cbase, coef_raddr, coef_waddr;
	logic                    coef_we;
	logic [DLY_AW-1:0]       dbase, dly_raddr, dly_waddr;
	logic                    dly_we;
	logic signed [DLY_W-1:0] dly_eff;
	logic signed [DLY_W-1:0] d_new;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] p_r15, p_r24;
	logic [63:0]              pu;
	logic signed [32:0]       bx;
	logic signed [DLY_W-1:0]  ay;
	logic signed [40:0]       ysum;
	logic signed [31:0]       y_sat;
	logic signed [41:0]       dsum;

	logic signed [35:0] z;
	logic [35:0]        t_abs;
	logic [28:0]        t_cl;
	logic [27:0]        r_new;
	logic [31:0]        h_new;

	logic               div_start, div_done;
	logic [QUO_W-1:0]   quo;
	logic [SIG_W-1:0]   sig;
	logic [24:0]        v_sum;
	logic [LEVEL_W-1:0] v_sat;

	cfbfe_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	cfbfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.h      (h_q),
		.done   (div_done),
		.quo    (quo)
	);

	// addresses
	assign cbase      = COEF_AW'(c_q * COEF_SLOTS);
	assign dbase      = DLY_AW'(c_q * FILTER_ORDER);
	assign coef_waddr = COEF_AW'(item_in.coef_channel * COEF_SLOTS + item_in.coef_slot);
	assign coef_we    = take && (item_in.op == OP_LOAD) && (item_in.coef_channel < CHANNELS)
		&& (item_in.coef_slot < COEF_SLOTS);
	assign dly_waddr  = dbase + DLY_AW'(k_q);

	// rounded products
	assign p_r15 = (prod_q + HALF15) >>> 15;
	assign p_r24 = (prod_q + HALF24) >>> 24;
	assign pu    = prod_q[63:0];
	assign bx    = p_r15[32:0];
	assign ay    = p_r24[DLY_W-1:0];
	assign dly_eff = dly_rd_vld_q ? dly_rd_q : '0;

	// filter output and delay update, both saturating
	assign ysum  = 41'(d_q) + 41'(bx);
	assign y_sat = (ysum > Y_MAX) ? 32'sh7fff_ffff : (ysum < Y_MIN) ? 32'sh8000_0000 : ysum[31:0];
	assign dsum  = acc_q - 42'(ay);
	assign d_new = (dsum > D_MAX) ? D_MAX[DLY_W-1:0] : (dsum < D_MIN) ? D_MIN[DLY_W-1:0]
		: dsum[DLY_W-1:0];

	// sigmoid argument: r = round(|10y| clamped to 16.0, / 2)
	assign z     = (36'(y_q) <<< 3) + (36'(y_q) <<< 1);
	assign t_abs = z[35] ? 36'(-z) : 36'(z);
	assign t_cl  = (t_abs > 36'd268435456) ? 29'd268435456 : t_abs[28:0];
	assign r_new = 28'((30'(t_cl) + 30'd1) >> 1);

	// exp(-r) Horner steps then squarings
	always_comb begin
		case (step_q)
			STEP_DIV5: h_new = ONE31 - 32'(pu >> 30);
			STEP_Q4:   h_new = ONE31 - 32'(pu >> 33);
			STEP_W3:   h_new = 32'(pu >> 31);
			STEP_DIV3: h_new = ONE31 - 32'(pu >> 30);
			STEP_Q2:   h_new = ONE31 - 32'(pu >> 32);
			STEP_Q1:   h_new = ONE31 - 32'(pu >> 31);
			default:   h_new = 32'((pu + 64'd1073741824) >> 31);
		endcase
	end

	assign sig = yneg_q ? SIG_W'(quo) : 16'd32768 - SIG_W'(quo);

	// leaky integrator
	assign v_sum = 25'({rect_q, 1'b0}) + 25'((pu + 64'd8388608) >> 24);
	assign v_sat = (v_sum > 25'(LEVEL_MAX)) ? LEVEL_MAX : v_sum[LEVEL_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (take && item_in.op == OP_SAMPLE) state_d = ST_B0_RD;
			ST_B0_RD:    state_d = ST_B0_MUL;
			ST_B0_MUL:   state_d = ST_Y;
			ST_Y:        state_d = ST_TAP_RD;
			ST_TAP_RD:   state_d = ST_TAP_BMUL;
			ST_TAP_BMUL: state_d = ST_TAP_AMUL;
			ST_TAP_AMUL: state_d = ST_TAP_WR;
			ST_TAP_WR:   state_d = (k_q == LAST_K) ? ST_SIG_MUL : ST_TAP_RD;
			ST_SIG_MUL:  state_d = ST_SIG_UPD;
			ST_SIG_UPD:  state_d = (step_q == STEP_END) ? ST_DIV_GO : ST_SIG_MUL;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) state_d = (c_q == '0) ? ST_B0_RD : ST_INT_MUL;
			end
			ST_INT_MUL:  state_d = ST_INT_UPD;
			ST_INT_UPD:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (res_ready) begin
					if (emit_q == LAST_CH)   state_d = ST_IDLE;
					else if (c_q == LAST_CH) state_d = ST_INT_MUL;
					else                     state_d = ST_B0_RD;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// control outputs, read addresses and multiplier operands
	always_comb begin
		busy       = (state_q != ST_IDLE);
		res_push   = (state_q == ST_EMIT) && res_ready;
		div_start  = (state_q == ST_DIV_GO);
		dly_we     = (state_q == ST_TAP_WR);
		coef_raddr = cbase;
		dly_raddr  = dbase;
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			ST_TAP_RD: begin
				coef_raddr = cbase + COEF_AW'(k_q) + COEF_AW'(1);
				if (k_q != LAST_K) dly_raddr = dbase + DLY_AW'(k_q) + DLY_AW'(1);
			end
			ST_TAP_BMUL: begin
				coef_raddr = cbase + COEF_AW'(k_q) + COEF_AW'(A_SLOT0);
				mul_a      = MUL_W'(coef_rd_q);
				mul_b      = MUL_W'(x_q);
			end
			ST_B0_MUL: begin
				mul_a = MUL_W'(coef_rd_q);
				mul_b = MUL_W'(x_q);
			end
			ST_TAP_AMUL: begin
				mul_a = MUL_W'(coef_rd_q);
				mul_b = MUL_W'(y_q);
			end
			ST_SIG_MUL: begin
				case (step_q) inside
					STEP_DIV5: begin
						mul_a = MUL_W'(r_q);
						mul_b = MUL_W'(RECIP5);
					end
					STEP_DIV3: begin
						mul_a = MUL_W'(h_q);
						mul_b = MUL_W'(RECIP3);
					end
					STEP_Q4, STEP_W3, STEP_Q2, STEP_Q1: begin
						mul_a = MUL_W'(r_q);
						mul_b = MUL_W'(h_q);
					end
					default: begin
						mul_a = MUL_W'(h_q);
						mul_b = MUL_W'(h_q);
					end
				endcase
			end
			ST_INT_MUL: begin
				mul_a = MUL_W'(integ_q[emit_q]);
				mul_b = MUL_W'(LEAK);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			c_q     <= '0;
			k_q     <= '0;
			step_q  <= '0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE:    c_q <= '0;
				ST_Y:       k_q <= '0;
				ST_TAP_WR: begin
					k_q    <= k_q + 1'b1;
					step_q <= STEP_DIV5;
				end
				ST_SIG_UPD: step_q <= step_q + 1'b1;
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (c_q == '0) c_q <= c_q + 1'b1;
						else           emit_q <= c_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (res_ready && emit_q != LAST_CH) begin
						if (c_q == LAST_CH) emit_q <= LAST_CH;
						else                c_q <= c_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:     x_q <= item_in.sample;
			ST_B0_MUL:   d_q <= dly_eff;
			ST_Y:        y_q <= y_sat;
			ST_TAP_BMUL: d_q <= (k_q == LAST_K) ? '0 : dly_eff;
			ST_TAP_AMUL: acc_q <= 42'(d_q) + 42'(bx);
			ST_TAP_WR: begin
				r_q    <= r_new;
				yneg_q <= y_q[31];
			end
			ST_SIG_UPD:  h_q <= h_new;
			ST_DIV_WAIT: begin
				if (div_done) begin
					rect_q     <= (sig_prev_q > sig) ? sig_prev_q - sig : '0;
					sig_prev_q <= sig;
				end
			end
			ST_INT_UPD: begin
				res_q.channel <= 6'(emit_q);
				res_q.level   <= v_sat;
				res_q.last    <= (emit_q == LAST_CH);
			end
			ST_EMIT: begin
				// last channel has nothing to subtract
				if (res_ready && c_q == LAST_CH) rect_q <= sig_prev_q;
			end
			default: begin
			end
		endcase
	end

	// coefficient memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (coef_we) coef_mem[coef_waddr] <= item_in.coef_value;
		coef_rd_q <= coef_mem[coef_raddr];
	end

	// delay memory
	always_ff @(posedge clk) begin
		if (dly_we) dly_mem[dly_waddr] <= d_new;
		dly_rd_q <= dly_mem[dly_raddr];
	end

	// delay valid bits, integrator values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_vld_q    <= '0;
			dly_rd_vld_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) integ_q[i] <= '0;
		end else begin
			dly_rd_vld_q <= dly_vld_q[dly_raddr];
			if (dly_we) dly_vld_q[dly_waddr] <= 1'b1;
			if (state_q == ST_INT_UPD) integ_q[emit_q] <= v_sat;
		end
	end

	assign res_word = res_q;

endmodule

>>> hdl/cochlear_filterbank_front_end.sv
// Top level of the cochlear filterbank front end: handshakes and output register.
// Depends on cfbfe_pkg and cfbfe_core.
//
//   channel | handshake                  | word
//   input   | item_valid / item_stall     | item (item_t)
//   output  | result_valid / result_stall | result (result_t)
//
// A coefficient load is written directly and leaves the block idle. An audio sample
// is run through every channel in turn: every filter tap, sigmoid step and
// integrator update goes through the single shared multiplier, plus 15 divider steps.
// Output stalls stretch this; the next word is taken once the last result is queued.
// Reset clears filter delays and integrators; coefficients must be loaded before use.
module cochlear_filterbank_front_end import cfbfe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic    take;
	logic    busy;
	logic    res_ready;
	logic    res_push;
	result_t res_word;
	logic    out_valid_q;
	result_t out_q;

	assign item_stall = busy;
	assign take       = item_valid & ~busy;
	assign res_ready  = ~out_valid_q | ~result_stall;

	cfbfe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item_in   (item),
		.res_ready (res_ready),
		.busy      (busy),
		.res_push  (res_push),
		.res_word  (res_word)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) out_q <= res_word;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> hdl/cfbfe_checker.sv
// Port-level checks of the cochlear filterbank front end, bound to the top level.
// Depends on cfbfe_pkg and cochlear_filterbank_front_end_assert.svh.
`include "cochlear_filterbank_front_end_assert.svh"

module cfbfe_checker import cfbfe_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled result word holds
	`CFBFE_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid && $stable(result))

	// a sample keeps the block busy, a coefficient load does not
	`CFBFE_ASSERT_NEXT(a_sample_busy, item_valid && !item_stall && item.op == OP_SAMPLE, item_stall)
	`CFBFE_ASSERT_NEXT(a_load_idle, item_valid && !item_stall && item.op == OP_LOAD, !item_stall)

	// while a non-final word waits, the final one is still to come
	`CFBFE_ASSERT_NOW(a_mid_busy, result_valid && !result.last, item_stall)

	// the final word belongs to the top channel
	`CFBFE_ASSERT_NOW(a_last_chan, result_valid && result.last, result.channel == 6'(CHANNELS - 1))

endmodule

bind cochlear_filterbank_front_end cfbfe_checker u_cfbfe_checker (.*);
